// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== design/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Types and constants shared by the counted bit trie cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

	localparam int FIELD_BITS = 18;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef struct packed {
		logic valid;
		act_t act;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/cbt_cell.sv =====
// ----------------------------------------------------------------------------
// cbt_cell
// One trie level: holds the sibling count pairs of its level and steps a
// transaction down by one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_cell #(
	parameter int KEY_BITS   = 18,
	parameter int COUNT_BITS = 16,
	parameter int LEVEL      = 1,
	parameter int CLR_BITS   = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cbt_pkg::cell_ctl_t     ctl_in,
	input  wire logic [KEY_BITS-1:0]    key_in,
	input  wire logic [KEY_BITS-1:0]    path_in,
	input  wire logic                   clr_en,
	input  wire logic [CLR_BITS-1:0]    clr_addr,
	output cbt_pkg::cell_ctl_t          ctl_out,
	output logic [KEY_BITS-1:0]         key_out,
	output logic [KEY_BITS-1:0]         path_out
);

	localparam int AW      = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int DEPTH   = 1 << AW;
	localparam int BIT_POS = KEY_BITS - LEVEL;

	logic [2*COUNT_BITS-1:0] mem [DEPTH];
	logic [2*COUNT_BITS-1:0] rd_q;
	cbt_pkg::cell_ctl_t      ctl_s1;
	logic [KEY_BITS-1:0]     key_s1;
	logic [KEY_BITS-1:0]     path_s1;

	logic                    kbit;
	logic [COUNT_BITS-1:0]   c0;
	logic [COUNT_BITS-1:0]   c1;
	logic [COUNT_BITS-1:0]   cur;
	logic [COUNT_BITS-1:0]   alt;
	logic [COUNT_BITS-1:0]   new_cnt;
	logic [2*COUNT_BITS-1:0] new_row;
	logic                    wr_en;
	logic                    obit;

	always_ff @(posedge clk) begin
		if (clr_en) begin
			mem[clr_addr[AW-1:0]] <= '0;
		end else if (wr_en) begin
			mem[path_s1[AW-1:0]] <= new_row;
		end
		if (ctl_in.valid) begin
			rd_q    <= mem[path_in[AW-1:0]];
			key_s1  <= key_in;
			path_s1 <= path_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, act: cbt_pkg::ACT_NONE};
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_comb begin
		kbit    = key_s1[BIT_POS];
		c0      = rd_q[COUNT_BITS-1:0];
		c1      = rd_q[2*COUNT_BITS-1:COUNT_BITS];
		cur     = kbit ? c1 : c0;
		alt     = kbit ? c0 : c1;
		new_cnt = cur;
		obit    = kbit;
		wr_en   = 1'b0;
		case (ctl_s1.act)
			cbt_pkg::ACT_INSERT: begin
				wr_en = ctl_s1.valid;
				if (cur != '1) begin
					new_cnt = cur + COUNT_BITS'(1);
				end
			end
			cbt_pkg::ACT_ERASE: begin
				wr_en = ctl_s1.valid;
				if (cur != '0) begin
					new_cnt = cur - COUNT_BITS'(1);
				end
			end
			cbt_pkg::ACT_QUERY: begin
				obit = (alt != '0) ? ~kbit : kbit;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		new_row  = kbit ? {new_cnt, c0} : {c1, new_cnt};
		ctl_out  = ctl_s1;
		key_out  = key_s1;
		path_out = (path_s1 << 1) | KEY_BITS'(obit);
	end

endmodule

`default_nettype wire

// ===== design/counted_bit_trie_max_xor.sv =====
// ----------------------------------------------------------------------------
// counted_bit_trie_max_xor
// Multiset of keys kept as per-node counts of a binary trie, answering
// maximum XOR queries.
// ----------------------------------------------------------------------------
// Channel   Signals                   Transfer
// input     start, action, key_value  start && !busy
// result    done, max_xor             done, one cycle, cannot be held off
//
// Each transaction passes one trie level per cycle along a chain of KEY_BITS
// cells, each with its own count memory. Busy stays high from acceptance until
// the transaction leaves the last cell; only one transaction is in the chain.
// After reset every cell memory is swept to zero, one row per cycle, over all
// 2^(KEY_BITS-1) clear addresses (at least 2), with busy held high.
// A query result is registered at the edge where the transaction leaves the
// last cell, as busy falls. Insert, erase and unused actions give no result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module counted_bit_trie_max_xor #(
	parameter int KEY_BITS   = 18,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         action,
	input  wire logic [cbt_pkg::FIELD_BITS-1:0]     key_value,
	output logic                                    done,
	output logic [cbt_pkg::FIELD_BITS-1:0]          max_xor
);

	localparam int CLR_BITS = (KEY_BITS > 1) ? KEY_BITS - 1 : 1;
	localparam int XW = (KEY_BITS > cbt_pkg::FIELD_BITS) ? KEY_BITS : cbt_pkg::FIELD_BITS;

	cbt_pkg::cell_ctl_t  ctl_c  [KEY_BITS+1];
	logic [KEY_BITS-1:0] key_c  [KEY_BITS+1];
	logic [KEY_BITS-1:0] path_c [KEY_BITS+1];
	logic [KEY_BITS-1:0] valid_vec;

	logic                clr_q;
	logic [CLR_BITS-1:0] clr_cnt_q;
	logic                inflight_q;
	logic                accept;
	logic [XW-1:0]       key_wide;
	logic [XW-1:0]       res_wide;

	assign busy     = clr_q | inflight_q;
	assign accept   = start & ~busy;
	assign key_wide = XW'(key_value);

	assign ctl_c[0]  = '{valid: accept, act: cbt_pkg::act_t'(action)};
	assign key_c[0]  = key_wide[KEY_BITS-1:0];
	assign path_c[0] = '0;

	for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
		cbt_cell #(
			.KEY_BITS  (KEY_BITS),
			.COUNT_BITS(COUNT_BITS),
			.LEVEL     (g + 1),
			.CLR_BITS  (CLR_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[g]),
			.key_in  (key_c[g]),
			.path_in (path_c[g]),
			.clr_en  (clr_q),
			.clr_addr(clr_cnt_q),
			.ctl_out (ctl_c[g+1]),
			.key_out (key_c[g+1]),
			.path_out(path_c[g+1])
		);
		assign valid_vec[g] = ctl_c[g+1].valid;
	end

	assign res_wide = XW'(key_c[KEY_BITS] ^ path_c[KEY_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_cnt_q  <= '0;
			inflight_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + CLR_BITS'(1);
				if (clr_cnt_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				inflight_q <= 1'b1;
			end else if (ctl_c[KEY_BITS].valid) begin
				inflight_q <= 1'b0;
			end
			done <= ctl_c[KEY_BITS].valid && (ctl_c[KEY_BITS].act == cbt_pkg::ACT_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_c[KEY_BITS].valid) begin
			max_xor <= res_wide[cbt_pkg::FIELD_BITS-1:0];
		end
	end

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_IMPLIES(a_clear_busy, clk, arst_n, clr_q, busy)
	`ASSERT_IMPLIES(a_one_item, clk, arst_n, 1'b1, $onehot0(valid_vec))

endmodule

`default_nettype wire
